// ----- hdl/sida_pkg.sv -----
// Shared constants, codes and control types for the slot id allocator.
package sida_pkg;

  localparam int SLOTS  = 1024;
  localparam int ID_W   = $clog2(SLOTS);
  localparam int CNT_W  = ID_W + 1;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);
  localparam logic [CNT_W-1:0] MAX_RST = CNT_W'(1024);
  localparam logic [ID_W-1:0]  RSV_RST = ID_W'(1);

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_INIT    = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic CFG_MAX = 1'b0;
  localparam logic CFG_RSV = 1'b1;

  typedef struct packed {
    logic init_start;
    logic sweep_step;
    logic emit_init;
    logic alloc_rd;
    logic alloc_wr;
    logic fl_start;
    logic fl_rdp;
    logic fl_rdm;
    logic fl_wr;
    logic fl_end;
    logic rel;
    logic bad;
  } sida_cmd_t;

  typedef struct packed {
    logic free_empty;
    logic fl_more;
    logic sweep_last;
  } sida_sts_t;

endpackage

// ----- hdl/sida_ctrl.sv -----
// Controller state machine: sequences sweeps, allocates and pending flushes.
module sida_ctrl import sida_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic [1:0] action,
  input  sida_sts_t sts,
  output sida_cmd_t cmd,
  output logic      busy
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SWEEP = 6'b000010,
    S_ALLOC = 6'b000100,
    S_FCHK  = 6'b001000,
    S_FRDM  = 6'b010000,
    S_FWR   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   emit_r, emit_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    emit_nxt  = emit_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (action)
            ACT_ALLOC: begin
              if (sts.free_empty) begin
                cmd.fl_start = 1'b1;
                state_nxt    = S_FCHK;
              end else begin
                cmd.alloc_rd = 1'b1;
                state_nxt    = S_ALLOC;
              end
            end
            ACT_RELEASE: cmd.rel = 1'b1;
            ACT_INIT: begin
              cmd.init_start = 1'b1;
              emit_nxt       = 1'b1;
              state_nxt      = S_SWEEP;
            end
            default: cmd.bad = 1'b1;
          endcase
        end
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          cmd.emit_init = emit_r;
          emit_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      S_ALLOC: begin
        cmd.alloc_wr = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_FCHK: begin
        if (sts.fl_more) begin
          cmd.fl_rdp = 1'b1;
          state_nxt  = S_FRDM;
        end else begin
          cmd.fl_end = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_FRDM: begin
        cmd.fl_rdm = 1'b1;
        state_nxt  = S_FWR;
      end
      S_FWR: begin
        cmd.fl_wr = 1'b1;
        state_nxt = S_FCHK;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      emit_r  <= emit_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- hdl/sida_dp.sv -----
// Datapath: free queue, free marks, pending list, counters and result registers.
module sida_dp import sida_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  sida_cmd_t        cmd,
  output sida_sts_t        sts,
  input  logic [ID_W-1:0]  slot_id,
  input  logic [CNT_W-1:0] max_clients,
  input  logic [ID_W-1:0]  reserved_slots,
  output logic             out_strobe,
  output logic [1:0]       out_status,
  output logic [ID_W-1:0]  out_granted_id,
  output logic [CNT_W-1:0] out_clients_in_use
);

  logic [ID_W-1:0] queue_mem [SLOTS];
  logic            mark_mem  [SLOTS];
  logic [ID_W-1:0] pend_mem  [SLOTS];

  logic [ID_W-1:0]  lo_r, lo_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [ID_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] pcnt_r, pcnt_nxt;
  logic [ID_W-1:0]  q_rd_r, pend_q_r;
  logic             mark_q_r;
  logic             strobe_r, strobe_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [ID_W-1:0]  granted_r, granted_nxt;
  logic [CNT_W-1:0] inuse_r, inuse_nxt;

  logic             q_we, m_we, m_wd, p_we;
  logic [ID_W-1:0]  q_wa, q_wd, m_wa;
  logic [ID_W-1:0]  idx_lo;
  logic             in_rng;
  logic [CNT_W-1:0] top, cfg_top;

  assign idx_lo  = idx_r[ID_W-1:0];
  assign in_rng  = (idx_lo >= lo_r) && ({1'b0, idx_lo} < hi_r);
  assign cfg_top = (max_clients > SLOTS_C) ? SLOTS_C : max_clients;
  assign top     = cfg_top;

  assign sts.free_empty = (cnt_r == '0);
  assign sts.fl_more    = (idx_r < pcnt_r);
  assign sts.sweep_last = (idx_lo == ID_W'(SLOTS - 1));

  always_comb begin
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    idx_nxt     = idx_r;
    head_nxt    = head_r;
    cnt_nxt     = cnt_r;
    pcnt_nxt    = pcnt_r;
    strobe_nxt  = 1'b0;
    status_nxt  = ST_OK;
    granted_nxt = '0;
    q_we = 1'b0;
    q_wa = idx_lo - lo_r;
    q_wd = idx_lo;
    m_we = 1'b0;
    m_wa = idx_lo;
    m_wd = in_rng;
    p_we = 1'b0;

    if (cmd.init_start) begin
      lo_nxt   = reserved_slots;
      hi_nxt   = cfg_top;
      idx_nxt  = '0;
      head_nxt = '0;
      cnt_nxt  = (cfg_top > {1'b0, reserved_slots}) ? cfg_top - {1'b0, reserved_slots} : '0;
      pcnt_nxt = '0;
    end
    if (cmd.sweep_step) begin
      m_we    = 1'b1;
      q_we    = in_rng;
      idx_nxt = idx_r + 1'b1;
    end
    if (cmd.emit_init) begin
      strobe_nxt = 1'b1;
    end
    if (cmd.alloc_wr) begin
      m_we        = 1'b1;
      m_wa        = q_rd_r;
      m_wd        = 1'b0;
      head_nxt    = head_r + 1'b1;
      cnt_nxt     = cnt_r - 1'b1;
      strobe_nxt  = 1'b1;
      granted_nxt = q_rd_r;
    end
    if (cmd.fl_start) begin
      idx_nxt = '0;
    end
    if (cmd.fl_rdp) begin
      idx_nxt = idx_r + 1'b1;
    end
    if (cmd.fl_wr && !mark_q_r && (cnt_r != SLOTS_C)) begin
      q_we    = 1'b1;
      q_wa    = head_r + cnt_r[ID_W-1:0];
      q_wd    = pend_q_r;
      m_we    = 1'b1;
      m_wa    = pend_q_r;
      m_wd    = 1'b1;
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.fl_end) begin
      pcnt_nxt   = '0;
      strobe_nxt = 1'b1;
      status_nxt = ST_EMPTY;
    end
    if (cmd.rel) begin
      strobe_nxt = 1'b1;
      if ((slot_id < reserved_slots) || ({1'b0, slot_id} >= cfg_top)) begin
        status_nxt = ST_REJECT;
      end else if (pcnt_r >= SLOTS_C) begin
        status_nxt = ST_FULL;
      end else begin
        p_we     = 1'b1;
        pcnt_nxt = pcnt_r + 1'b1;
      end
    end
    if (cmd.bad) begin
      strobe_nxt = 1'b1;
      status_nxt = ST_REJECT;
    end
    inuse_nxt = (cnt_nxt > top) ? '0 : top - cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r     <= RSV_RST;
      hi_r     <= MAX_RST;
      idx_r    <= '0;
      head_r   <= '0;
      cnt_r    <= MAX_RST - {1'b0, RSV_RST};
      pcnt_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      lo_r     <= lo_nxt;
      hi_r     <= hi_nxt;
      idx_r    <= idx_nxt;
      head_r   <= head_nxt;
      cnt_r    <= cnt_nxt;
      pcnt_r   <= pcnt_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    granted_r <= granted_nxt;
    inuse_r   <= inuse_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[q_wa] <= q_wd;
    end
    if (cmd.alloc_rd) begin
      q_rd_r <= queue_mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (m_we) begin
      mark_mem[m_wa] <= m_wd;
    end
    if (cmd.fl_rdm) begin
      mark_q_r <= mark_mem[pend_q_r];
    end
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      pend_mem[pcnt_r[ID_W-1:0]] <= slot_id;
    end
    if (cmd.fl_rdp) begin
      pend_q_r <= pend_mem[idx_lo];
    end
  end

  assign out_strobe         = strobe_r;
  assign out_status         = status_r;
  assign out_granted_id     = granted_r;
  assign out_clients_in_use = inuse_r;

endmodule

// ----- hdl/slot_id_allocator_deferred_reuse.sv -----
// Top level: configuration registers, controller and datapath of the slot id allocator.
//
//  channel   | ports                                        | beat taken when
//  ----------+----------------------------------------------+-------------------------------
//  command   | start, busy, in_action, in_slot_id           | start && !busy
//  result    | out_strobe, out_status, out_granted_id,      | out_strobe (one cycle, no stall)
//            | out_clients_in_use                           |
//  config    | psel, penable, pwrite, paddr, pwdata,        | psel && penable && pwrite
//            | prdata, pready                               |
//
// Release and unknown action: handled in the idle state. Allocate: queue memory read, then update.
// Allocate on an empty free list: pending flush with a pending read, mark read and queue write
// per entry. Init: sweeps every slot, one mark per cycle plus a queue entry per slot in range.
// After reset a sweep rebuilds the free list; busy stays high meanwhile.
// The result comes in the cycle after the last work cycle; the receiver cannot stall.
module slot_id_allocator_deferred_reuse import sida_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_action,
  input  logic [ID_W-1:0]   in_slot_id,
  output logic              out_strobe,
  output logic [1:0]        out_status,
  output logic [ID_W-1:0]   out_granted_id,
  output logic [CNT_W-1:0]  out_clients_in_use,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [CNT_W-1:0] cfg_max_r;
  logic [ID_W-1:0]  cfg_rsv_r;
  logic             cfg_wr;
  sida_cmd_t        cmd;
  sida_sts_t        sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_max_r <= MAX_RST;
      cfg_rsv_r <= RSV_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        CFG_MAX: cfg_max_r <= pwdata[CNT_W-1:0];
        CFG_RSV: cfg_rsv_r <= pwdata[ID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CFG_MAX: prdata = DATA_W'(cfg_max_r);
      CFG_RSV: prdata = DATA_W'(cfg_rsv_r);
      default: prdata = '0;
    endcase
  end

  sida_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_action),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  sida_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .slot_id            (in_slot_id),
    .max_clients        (cfg_max_r),
    .reserved_slots     (cfg_rsv_r),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_granted_id     (out_granted_id),
    .out_clients_in_use (out_clients_in_use)
  );

endmodule

// ----- hdl/sida_chk.sv -----
// Port-level checker for the slot id allocator, bound to the top level.
module sida_chk import sida_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic [1:0]       in_action,
  input logic             out_strobe,
  input logic [1:0]       out_status,
  input logic [ID_W-1:0]  out_granted_id,
  input logic [CNT_W-1:0] out_clients_in_use
);

  a_rst_sweep: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  a_rel_beat: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_action == ACT_RELEASE) |=> out_strobe)
    else $error("release result missing");

  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status != ST_OK) |-> (out_granted_id == '0))
    else $error("granted id set on failed beat");

  a_inuse_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_clients_in_use <= SLOTS_C))
    else $error("clients in use out of range");

endmodule

bind slot_id_allocator_deferred_reuse sida_chk u_sida_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_action          (in_action),
  .out_strobe         (out_strobe),
  .out_status         (out_status),
  .out_granted_id     (out_granted_id),
  .out_clients_in_use (out_clients_in_use)
);

// ----- tb/testbench.sv -----
// Testbench for the slot id allocator: directed and random command beats checked against a predictor.
`timescale 1ns / 100ps

module testbench;
  import sida_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int ITEMS_PER_PHASE = 42;
  localparam int RANDOM_PHASES = 12;

  typedef struct {
    logic [1:0]      action;
    logic [ID_W-1:0] slot;
  } slot_cmd_t;

  typedef struct {
    logic [1:0]       status;
    logic [ID_W-1:0]  granted;
    logic [CNT_W-1:0] in_use;
  } slot_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_action = ACT_ALLOC;
  logic [ID_W-1:0]   in_slot_id = '0;
  logic              out_strobe;
  logic [1:0]        out_status;
  logic [ID_W-1:0]   out_granted_id;
  logic [CNT_W-1:0]  out_clients_in_use;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  slot_id_allocator_deferred_reuse dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_slot_id(in_slot_id),
    .out_strobe(out_strobe), .out_status(out_status),
    .out_granted_id(out_granted_id), .out_clients_in_use(out_clients_in_use),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // allocator image
  int              max_clients_cfg;
  int              reserved_cfg;
  logic [ID_W-1:0] free_ring [SLOTS];
  int              free_head;
  int              free_cnt;
  bit              free_flag [SLOTS];
  logic [ID_W-1:0] pend_ids [SLOTS];
  int              pend_cnt;

  slot_cmd_t    command_queue [$];
  slot_result_t expected_results [$];
  int           sender_idle_pct = 20;
  int           fail_count = 0;
  int           cycle_count = 0;
  slot_cmd_t    next_cmd;
  slot_result_t want;

  function automatic int id_bound();
    return (max_clients_cfg > SLOTS) ? SLOTS : max_clients_cfg;
  endfunction

  function automatic void push_free(logic [ID_W-1:0] id);
    if (free_cnt >= SLOTS) return;
    free_ring[(free_head + free_cnt) % SLOTS] = id;
    free_flag[id] = 1'b1;
    free_cnt++;
  endfunction

  function automatic void rebuild_free_list();
    int top;
    top = id_bound();
    foreach (free_flag[i]) free_flag[i] = 1'b0;
    free_head = 0;
    free_cnt = 0;
    pend_cnt = 0;
    for (int id = reserved_cfg; id < top; id++) push_free(ID_W'(id));
  endfunction

  function automatic slot_result_t predict_slot_result(slot_cmd_t cmd);
    slot_result_t res;
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] last_id;
    bit last_valid;
    int top;
    res.status = ST_OK;
    res.granted = '0;
    last_id = '0;
    last_valid = 1'b0;
    case (cmd.action)
      ACT_ALLOC: begin
        if (free_cnt == 0) begin
          for (int i = 0; i < pend_cnt; i++) begin
            id = pend_ids[i];
            if (last_valid && id == last_id) continue;
            if (free_flag[id]) continue;
            push_free(id);
            last_id = id;
            last_valid = 1'b1;
          end
          pend_cnt = 0;
          res.status = ST_EMPTY;
        end else begin
          res.granted = free_ring[free_head];
          free_flag[res.granted] = 1'b0;
          free_head = (free_head + 1) % SLOTS;
          free_cnt--;
        end
      end
      ACT_RELEASE: begin
        if (int'(cmd.slot) < reserved_cfg || int'(cmd.slot) >= id_bound()) begin
          res.status = ST_REJECT;
        end else if (pend_cnt >= SLOTS) begin
          res.status = ST_FULL;
        end else begin
          pend_ids[pend_cnt] = cmd.slot;
          pend_cnt++;
        end
      end
      ACT_INIT: rebuild_free_list();
      default: res.status = ST_REJECT;
    endcase
    top = id_bound();
    res.in_use = (free_cnt > top) ? '0 : CNT_W'(top - free_cnt);
    return res;
  endfunction

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.insert(expected_results.size(),
                                predict_slot_result('{in_action, in_slot_id}));
      end
      if (!start || !busy) begin
        if (command_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_cmd = command_queue[0];
          command_queue.delete(0);
          start <= 1'b1;
          in_action <= next_cmd.action;
          in_slot_id <= next_cmd.slot;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result beat: status %0d id %0d in_use %0d",
                   out_status, out_granted_id, out_clients_in_use);
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (out_status !== want.status || out_granted_id !== want.granted ||
            out_clients_in_use !== want.in_use) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: status %0d/%0d id %0d/%0d in_use %0d/%0d (exp/act)",
                     want.status, out_status, want.granted, out_granted_id,
                     want.in_use, out_clients_in_use);
        end
      end
    end
  end

  task automatic queue_cmd(logic [1:0] action, int slot);
    slot_cmd_t entry;
    entry.action = action;
    entry.slot = ID_W'(slot);
    command_queue.insert(command_queue.size(), entry);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (command_queue.size() != 0 || start || busy || expected_results.size() != 0);
  endtask

  task automatic write_reg(logic idx, int unsigned value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == CFG_MAX) max_clients_cfg = value & 32'h7FF;
    else reserved_cfg = value & 32'h3FF;
  endtask

  task automatic reconfigure(int max_c, int rsv);
    wait_drained();
    write_reg(CFG_MAX, max_c);
    write_reg(CFG_RSV, rsv);
  endtask

  task automatic queue_random_cmds(int count, int max_c, int rsv);
    int top;
    int pick;
    int last_rel;
    int slot;
    top = (max_c > SLOTS) ? SLOTS : max_c;
    last_rel = -1;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      slot = $urandom_range(SLOTS - 1);
      if (pick < 45) begin
        queue_cmd(ACT_ALLOC, slot);
      end else if (pick < 93) begin
        if (pick < 88 && top > rsv) begin
          if (last_rel >= 0 && $urandom_range(7) == 0) slot = last_rel;
          else slot = rsv + $urandom_range(top - rsv - 1);
        end
        last_rel = slot;
        queue_cmd(ACT_RELEASE, slot);
      end else if (pick < 97) begin
        queue_cmd(ACT_INIT, slot);
      end else begin
        queue_cmd(ACT_UNUSED, slot);
      end
    end
  endtask

  int max_pick;
  int rsv_pick;

  initial begin
    max_clients_cfg = MAX_RST;
    reserved_cfg = RSV_RST;
    rebuild_free_list();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults
    queue_cmd(ACT_ALLOC, 0);
    queue_cmd(ACT_RELEASE, 0);
    queue_cmd(ACT_RELEASE, SLOTS - 1);
    queue_cmd(ACT_RELEASE, 1);
    queue_cmd(ACT_UNUSED, 5);

    // repeated and already-free ids in the flush
    reconfigure(4, 1);
    queue_cmd(ACT_INIT, 0);
    queue_cmd(ACT_ALLOC, 0);
    queue_cmd(ACT_ALLOC, 0);
    queue_cmd(ACT_RELEASE, 2);
    queue_cmd(ACT_RELEASE, 2);
    queue_cmd(ACT_RELEASE, 3);
    queue_cmd(ACT_RELEASE, 2);
    queue_cmd(ACT_RELEASE, 1);
    queue_cmd(ACT_RELEASE, 4);
    queue_cmd(ACT_ALLOC, 0);
    queue_cmd(ACT_ALLOC, 0);
    queue_cmd(ACT_ALLOC, 0);
    queue_cmd(ACT_ALLOC, 0);
    queue_cmd(ACT_ALLOC, 0);

    reconfigure(1, 0);
    queue_cmd(ACT_INIT, 0);
    queue_cmd(ACT_ALLOC, 0);
    queue_cmd(ACT_ALLOC, 0);
    queue_cmd(ACT_RELEASE, 0);
    queue_cmd(ACT_ALLOC, 0);
    queue_cmd(ACT_ALLOC, 0);

    reconfigure(2047, 1023);
    queue_cmd(ACT_INIT, 0);
    queue_cmd(ACT_RELEASE, 1023);
    queue_cmd(ACT_ALLOC, 0);
    queue_cmd(ACT_RELEASE, 1022);

    // reserved range covers every id: empty free list
    reconfigure(1000, 1023);
    queue_cmd(ACT_INIT, 0);
    queue_cmd(ACT_ALLOC, 0);

    // shrink max below the free count
    reconfigure(1024, 0);
    queue_cmd(ACT_INIT, 0);
    reconfigure(1, 0);
    queue_cmd(ACT_RELEASE, 5);
    queue_cmd(ACT_RELEASE, 0);

    // release many repeated ids, then flush them
    reconfigure(8, 0);
    queue_cmd(ACT_INIT, 0);
    repeat (8) queue_cmd(ACT_ALLOC, 0);
    repeat (40) queue_cmd(ACT_RELEASE, $urandom_range(7));
    queue_cmd(ACT_ALLOC, 0);
    queue_cmd(ACT_ALLOC, 0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph % 4 == 3) begin
        case ($urandom_range(3))
          0: max_pick = 1;
          1: max_pick = SLOTS;
          2: max_pick = 2047;
          default: max_pick = $urandom_range(1, 2047);
        endcase
        case ($urandom_range(2))
          0: rsv_pick = 0;
          1: rsv_pick = 1023;
          default: rsv_pick = $urandom_range(1023);
        endcase
      end else begin
        max_pick = $urandom_range(2, 40);
        rsv_pick = $urandom_range(4);
      end
      reconfigure(max_pick, rsv_pick);
      sender_idle_pct = (ph < 4) ? 20 : (ph < 8) ? 83 : 0;
      queue_cmd(ACT_INIT, $urandom_range(SLOTS - 1));
      queue_random_cmds(ITEMS_PER_PHASE, max_pick, rsv_pick);
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
